// ===== rtl/spba_pkg.sv =====
`default_nettype none

package spba_pkg;

  // Default number of bins
  localparam int unsigned BIN_COUNT_DEF = 4096;

  // Bin sums and counts never pass BIN_FIELD_MAX
  localparam logic [30:0] BIN_FIELD_MAX = 31'h7FFF_FFFF;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAIR_DELTA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_DISTANCE = 2'd2;

  localparam logic [CFG_DATA_W-1:0] LOW_THRESHOLD_RST     = 12'd0;
  localparam logic [CFG_DATA_W-1:0] MAX_PAIR_DELTA_RST    = 12'd4095;
  localparam logic [CFG_DATA_W-1:0] MAX_STEP_DISTANCE_RST = 12'd4095;

  // Commands
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_ACCEPTED  = 2'd0;
  localparam logic [1:0] STATUS_DROPPED   = 2'd1;
  localparam logic [1:0] STATUS_DISCARDED = 2'd2;
  localparam logic [1:0] STATUS_RANGE     = 2'd3;

  // Input beat
  typedef struct packed {
    logic        command;
    logic [15:0] ref_reading;
    logic [15:0] dut_reading;
    logic [11:0] read_index;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] bin_sum;
    logic [30:0] bin_count;
    logic [31:0] total_pairs;
    logic [31:0] valid_pairs;
    logic [31:0] dropped_pairs;
    logic [31:0] discarded_pairs;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;  // write zero at the clear pointer, advance it
    logic latch_item;  // capture the input beat
    logic commit;      // update state and load the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // clear pointer is at the last bin
    logic out_free;    // output register can take a result this cycle
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/spba_ram.sv =====
`default_nettype none

module spba_ram #(
  parameter int unsigned WIDTH = 62,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/spba_datapath.sv =====
`default_nettype none

module spba_datapath #(
  parameter int unsigned BIN_COUNT = spba_pkg::BIN_COUNT_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [spba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [spba_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire spba_pkg::in_t                    in_data_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output spba_pkg::out_t                        out_data_o,
  input  wire spba_pkg::ctrl_cmd_t              cmd_i,
  output spba_pkg::ctrl_sts_t                   sts_o
);

  localparam int unsigned BIN_W = $clog2(BIN_COUNT);
  localparam int unsigned RAM_W = 62;
  localparam logic [16:0] BIN_LIM = 17'(BIN_COUNT);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BIN_COUNT - 1);

  function automatic logic [16:0] absdiff(input logic [16:0] a, input logic [16:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // Configuration registers
  logic [spba_pkg::CFG_DATA_W-1:0] low_thr_q, max_delta_q, max_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q   <= spba_pkg::LOW_THRESHOLD_RST;
      max_delta_q <= spba_pkg::MAX_PAIR_DELTA_RST;
      max_step_q  <= spba_pkg::MAX_STEP_DISTANCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spba_pkg::REG_LOW_THRESHOLD:     low_thr_q   <= cfg_data_i;
        spba_pkg::REG_MAX_PAIR_DELTA:    max_delta_q <= cfg_data_i;
        spba_pkg::REG_MAX_STEP_DISTANCE: max_step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item register
  spba_pkg::in_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_q <= in_data_i;
    end
  end

  // Clear pointer for the post-reset sweep
  logic [BIN_W-1:0] clr_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_ptr_q <= clr_ptr_q + BIN_W'(1);
    end
  end

  // Bin store: {sum, count}
  logic [16:0]      ref17, dut17, ridx17;
  logic [BIN_W-1:0] ref_bin, rd_addr;
  logic             ram_we;
  logic [BIN_W-1:0] ram_waddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;

  assign ref17   = {1'b0, item_q.ref_reading};
  assign dut17   = {1'b0, item_q.dut_reading};
  assign ridx17  = {5'b0, item_q.read_index};
  assign ref_bin = ref17[BIN_W-1:0];
  assign rd_addr = (item_q.command == spba_pkg::CMD_ADD) ? ref_bin : ridx17[BIN_W-1:0];

  spba_ram #(
    .WIDTH(RAM_W),
    .DEPTH(BIN_COUNT)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // State and counters
  logic [BIN_W-1:0] prev_ref_q, prev_dut_q;
  logic [31:0]      total_q, valid_q, dropped_q, discarded_q;

  // Item evaluation
  logic [30:0] sum_old, cnt_old, sum_new, cnt_new;
  logic [31:0] sum_wide;
  logic [31:0] total_d, valid_d, dropped_d, discarded_d;
  logic [BIN_W-1:0] prev_ref_d, prev_dut_d;
  logic        in_range, low, delta_bad, far, ovf, acc;
  logic [1:0]  status;
  logic [30:0] bs, bc;

  assign sum_old  = ram_rdata[61:31];
  assign cnt_old  = ram_rdata[30:0];
  assign sum_wide = {1'b0, sum_old} + {15'b0, dut17};
  assign sum_new  = sum_wide[30:0];
  assign cnt_new  = cnt_old + 31'd1;

  always_comb begin
    total_d     = total_q;
    valid_d     = valid_q;
    dropped_d   = dropped_q;
    discarded_d = discarded_q;
    prev_ref_d  = prev_ref_q;
    prev_dut_d  = prev_dut_q;
    acc         = 1'b0;
    status      = spba_pkg::STATUS_ACCEPTED;
    bs          = '0;
    bc          = '0;

    in_range  = (ref17 < BIN_LIM) && (dut17 < BIN_LIM);
    low       = (ref17 < 17'(low_thr_q)) || (dut17 < 17'(low_thr_q));
    delta_bad = absdiff(ref17, dut17) > 17'(max_delta_q);
    far       = ((total_q + 32'd1) > 32'd1) &&
                ((absdiff(ref17, 17'(prev_ref_q)) > 17'(max_step_q)) ||
                 (absdiff(dut17, 17'(prev_dut_q)) > 17'(max_step_q)));
    ovf       = (cnt_old == spba_pkg::BIN_FIELD_MAX) || sum_wide[31];

    if (item_q.command == spba_pkg::CMD_ADD) begin
      if (!in_range) begin
        status = spba_pkg::STATUS_RANGE;
      end else begin
        total_d = total_q + 32'd1;
        if (low) begin
          dropped_d = dropped_q + 32'd1;
          status    = spba_pkg::STATUS_DROPPED;
        end else if (delta_bad) begin
          discarded_d = discarded_q + 32'd1;
          status      = spba_pkg::STATUS_DISCARDED;
        end else begin
          // previous readings move even when the step check fails
          prev_ref_d = ref_bin;
          prev_dut_d = dut17[BIN_W-1:0];
          if (far || ovf) begin
            discarded_d = discarded_q + 32'd1;
            status      = spba_pkg::STATUS_DISCARDED;
          end else begin
            valid_d = valid_q + 32'd1;
            acc     = 1'b1;
          end
        end
        bs = acc ? sum_new : sum_old;
        bc = acc ? cnt_new : cnt_old;
      end
    end else if (ridx17 < BIN_LIM) begin
      bs = sum_old;
      bc = cnt_old;
    end else begin
      status = spba_pkg::STATUS_RANGE;
    end
  end

  // Bin write: zero during the sweep, accumulated pair on commit
  assign ram_we    = cmd_i.clear_step || (cmd_i.commit && acc);
  assign ram_waddr = cmd_i.clear_step ? clr_ptr_q : ref_bin;
  assign ram_wdata = cmd_i.clear_step ? '0 : {sum_new, cnt_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ref_q  <= '0;
      prev_dut_q  <= '0;
      total_q     <= '0;
      valid_q     <= '0;
      dropped_q   <= '0;
      discarded_q <= '0;
    end else if (cmd_i.commit) begin
      prev_ref_q  <= prev_ref_d;
      prev_dut_q  <= prev_dut_d;
      total_q     <= total_d;
      valid_q     <= valid_d;
      dropped_q   <= dropped_d;
      discarded_q <= discarded_d;
    end
  end

  // Output register
  logic           out_valid_q;
  spba_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.status          <= status;
      out_q.bin_sum         <= bs;
      out_q.bin_count       <= bc;
      out_q.total_pairs     <= total_d;
      out_q.valid_pairs     <= valid_d;
      out_q.dropped_pairs   <= dropped_d;
      out_q.discarded_pairs <= discarded_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.clear_last = (clr_ptr_q == LAST_BIN);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== rtl/spba_ctrl.sv =====
`default_nettype none

module spba_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire spba_pkg::ctrl_sts_t sts_i,
  output spba_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   accept;

  assign accept = in_valid_i && in_ready_q;

  // State and ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      in_ready_q <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q    <= S_FETCH;
            in_ready_q <= 1'b0;
          end
        end
        S_FETCH: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (sts_i.out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_CLEAR;
          in_ready_q <= 1'b0;
        end
      endcase
    end
  end

  // Datapath commands
  assign cmd_o.clear_step = (state_q == S_CLEAR);
  assign cmd_o.latch_item = accept;
  assign cmd_o.commit     = (state_q == S_EXEC) && sts_i.out_free;

  assign in_ready_o = in_ready_q;

endmodule

`default_nettype wire

// ===== rtl/sample_pair_bin_accumulator.sv =====
// Flow: an accepted input beat is registered, its bin is read through the
// single registered-read bin RAM (read-modify-write), and the result is loaded
// into the output register once it is free; no new item is taken before then.
// Reset: asynchronous, active low; afterwards a clearing pass writes zero to
// every bin, one bin a cycle, before the first item is taken.
`default_nettype none

module sample_pair_bin_accumulator #(
  parameter int unsigned BIN_COUNT = spba_pkg::BIN_COUNT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [spba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [spba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire spba_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output spba_pkg::out_t                       out_data_o
);

  spba_pkg::ctrl_cmd_t cmd;
  spba_pkg::ctrl_sts_t sts;

  spba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  spba_datapath #(
    .BIN_COUNT(BIN_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire
